// File: design/trp_pkg.sv
package trp_pkg;

  localparam int unsigned PrescaleStepsDef = 72;
  localparam int unsigned PeriodFracBitsDef = 16;

  localparam int unsigned FreqW  = 27;
  localparam int unsigned PscW   = 8;
  localparam int unsigned RelW   = 16;
  localparam int unsigned StepW  = 6;
  localparam int unsigned ShareW = 10;
  localparam int unsigned ClkW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned DenW   = 36;  // 360 * f

  localparam logic [CfgIdxW-1:0] RegShare   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMaxFreq = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMaxRel  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegClk     = 2'd3;

  localparam logic [ShareW-1:0] ShareRst  = 10'd20;
  localparam logic [FreqW-1:0]  MaxFreqRst = 27'd4000000;
  localparam logic [RelW-1:0]   MaxRelRst = 16'd65000;
  localparam logic [ClkW-1:0]   ClkRst    = 8'd72;
  localparam logic [StepW-1:0]  StepRst   = 6'd10;

  typedef struct packed {
    logic load_in;
    logic cmp;
    logic mul1;
    logic mul2;
    logic hold_zero;
    logic p_start;
    logic p_latch;
    logic psc_inc;
    logic q_start;
    logic q_latch;
    logic fit;
    logic hold;
    logic out_load;
  } trp_cmd_t;

  typedef struct packed {
    logic upd;
    logic f_zero;
    logic psc_end;
    logic cand;
    logic fits;
    logic div_done;
  } trp_stat_t;

  function automatic logic [StepW-1:0] band_step(input logic [FreqW-1:0] f,
                                                 input logic [StepW-1:0] keep);
    logic [StepW-1:0] s;
    if (f < 27'd100)         s = keep;
    else if (f <= 27'd1000)   s = 6'd1;
    else if (f <= 27'd250000) s = 6'd10;
    else if (f <= 27'd500000) s = 6'd20;
    else if (f <= 27'd750000) s = 6'd30;
    else                      s = 6'd40;
    return s;
  endfunction

endpackage

// File: design/trp_div.sv
module trp_div #(
  parameter int unsigned NumW = 56,
  parameter int unsigned DvsW = 36
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(NumW);

  logic [NumW-1:0] dvd_q, dvd_d;
  logic [DvsW-1:0] dvs_q, dvs_d;
  logic [DvsW:0]   rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DvsW:0]   trial;

  // restoring divider, one quotient bit per cycle
  always_comb begin
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DvsW-1:0], dvd_q[NumW-1]};
    if (start_i) begin
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = CntW'(NumW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        dvd_d = {dvd_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        dvd_d = {dvd_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

// File: design/trp_dp.sv
module trp_dp #(
  parameter int unsigned PRESCALE_STEPS   = 72,
  parameter int unsigned PERIOD_FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  trp_pkg::trp_cmd_t           cmd_i,
  output trp_pkg::trp_stat_t          stat_o,
  input  logic                        cfg_we_i,
  input  logic [trp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [trp_pkg::FreqW-1:0]   cfg_data_i,
  input  logic [trp_pkg::FreqW-1:0]   freq_i,
  output logic                        updated_o,
  output logic [trp_pkg::PscW-1:0]    prescaler_o,
  output logic [trp_pkg::RelW-1:0]    reload_o,
  output logic [trp_pkg::StepW-1:0]   step_o,
  output logic                        clamped_o
);
  import trp_pkg::*;

  localparam int unsigned F    = PERIOD_FRAC_BITS;
  localparam int unsigned NumW = 40 + F;  // 1e8*s*clk < 2^40
  localparam int unsigned PW   = 32 + F;  // period bound
  localparam int unsigned CmpW = PW + 11;
  localparam logic [PscW-1:0] PscEnd = PscW'(PRESCALE_STEPS);
  localparam logic [PW-1:0]   Half   = PW'(1) << (F - 1);

  logic [ShareW-1:0] share_q;
  logic [FreqW-1:0]  maxf_q;
  logic [RelW-1:0]   maxrel_q;
  logic [ClkW-1:0]   tclk_q;

  logic [FreqW-1:0]  f_q, last_q;
  logic [StepW-1:0]  step_q;
  logic [PscW-1:0]   hpsc_q, psc_q;
  logic [RelW-1:0]   hrel_q, rel_q;
  logic              upd_q, clamp_q;
  logic [13:0]       sc_q;
  logic [NumW-1:0]   num_q;
  logic [DenW-1:0]   den_q;
  logic [PW-1:0]     p_q, e_q;
  logic              oupd_q, oclamp_q;
  logic [PscW-1:0]   opsc_q;
  logic [RelW-1:0]   orel_q;
  logic [StepW-1:0]  ostep_q;

  logic [FreqW-1:0]  diff, fc;
  logic [36:0]       lhs_chg, rhs_chg;
  logic [PscW-1:0]   d;
  logic [PW-1:0]     cand_val, fit_val, q_minus;
  logic [CmpW-1:0]   lhs_fit, rhs_fit;
  logic              div_start, div_done;
  logic [NumW-1:0]   div_num, div_quot;
  logic [DenW-1:0]   div_den;
  logic [40:0]       num_raw;

  assign diff    = (f_q >= last_q) ? (f_q - last_q) : (last_q - f_q);
  assign lhs_chg = 37'(diff) * 37'd1000;
  assign rhs_chg = 37'(share_q) * 37'(f_q);
  assign fc      = (f_q > maxf_q) ? maxf_q : f_q;
  assign d       = psc_q + 1'b1;
  assign cand_val = PW'({maxrel_q, d}) == '0 ? '0 : PW'(32'(maxrel_q) * 32'(d)) << F;
  assign q_minus = div_quot[PW-1:0] - Half;
  assign fit_val = PW'(32'({1'b0, rel_q} + 17'd1) * 32'(d)) << F;
  assign lhs_fit = CmpW'(e_q) * CmpW'(1800);
  assign rhs_fit = CmpW'(p_q) * CmpW'(step_q);
  assign num_raw = 41'(sc_q) * 41'd100000000;

  assign div_start = cmd_i.p_start | cmd_i.q_start;
  assign div_num   = cmd_i.p_start ? num_q : NumW'(p_q);
  assign div_den   = cmd_i.p_start ? den_q : DenW'(d);

  trp_div #(.NumW(NumW), .DvsW(DenW)) u_div (
    .clk_i, .rst_ni,
    .start_i   (div_start),
    .dividend_i(div_num),
    .divisor_i (div_den),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  assign stat_o.upd      = lhs_chg > rhs_chg;
  assign stat_o.f_zero   = last_q == '0;
  assign stat_o.psc_end  = psc_q == PscEnd;
  assign stat_o.cand     = cand_val > p_q;
  assign stat_o.fits     = lhs_fit < rhs_fit;
  assign stat_o.div_done = div_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      share_q  <= ShareRst;
      maxf_q   <= MaxFreqRst;
      maxrel_q <= MaxRelRst;
      tclk_q   <= ClkRst;
      last_q   <= '0;
      step_q   <= StepRst;
      hpsc_q   <= '0;
      hrel_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegShare:   share_q  <= cfg_data_i[ShareW-1:0];
          RegMaxFreq: maxf_q   <= cfg_data_i;
          RegMaxRel:  maxrel_q <= cfg_data_i[RelW-1:0];
          RegClk:     tclk_q   <= cfg_data_i[ClkW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.cmp && stat_o.upd) begin
        last_q <= fc;
        step_q <= band_step(fc, step_q);
      end
      if (cmd_i.hold_zero) begin
        hpsc_q <= PscEnd;
        hrel_q <= '0;
      end
      if (cmd_i.hold) begin
        hpsc_q <= psc_q;
        hrel_q <= rel_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) f_q <= freq_i;
    if (cmd_i.cmp) begin
      upd_q   <= stat_o.upd;
      clamp_q <= f_q > maxf_q;
    end
    if (cmd_i.mul1) sc_q <= 14'(step_q) * 14'(tclk_q);
    if (cmd_i.mul2) begin
      num_q <= NumW'(num_raw[39:0]) << F;
      den_q <= DenW'(last_q) * DenW'(360);
    end
    if (cmd_i.p_latch) begin
      p_q   <= div_quot[PW-1:0];
      psc_q <= '0;
      rel_q <= '0;
    end
    if (cmd_i.psc_inc) psc_q <= psc_q + 1'b1;
    if (cmd_i.q_latch)
      rel_q <= (div_quot[PW-1:0] >= Half) ? q_minus[F+RelW-1:F] : '0;
    if (cmd_i.fit) e_q <= (p_q >= fit_val) ? (p_q - fit_val) : (fit_val - p_q);
    if (cmd_i.out_load) begin
      oupd_q   <= upd_q;
      oclamp_q <= upd_q & clamp_q;
      opsc_q   <= hpsc_q;
      orel_q   <= hrel_q;
      ostep_q  <= step_q;
    end
  end

  assign updated_o   = oupd_q;
  assign clamped_o   = oclamp_q;
  assign prescaler_o = opsc_q;
  assign reload_o    = orel_q;
  assign step_o      = ostep_q;

endmodule

// File: design/trp_ctrl.sv
module trp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  trp_pkg::trp_stat_t  stat_i,
  output trp_pkg::trp_cmd_t   cmd_o
);
  import trp_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CMP  = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_MUL2 = 4'd3;
  localparam logic [3:0] S_PGO  = 4'd4;
  localparam logic [3:0] S_PDIV = 4'd5;
  localparam logic [3:0] S_CAND = 4'd6;
  localparam logic [3:0] S_QDIV = 4'd7;
  localparam logic [3:0] S_FIT  = 4'd8;
  localparam logic [3:0] S_CHK  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;
  logic       slot_free;

  assign slot_free  = !ovalid_q || out_ready_i;
  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    ovalid_d = ovalid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d = stat_i.upd ? S_MUL1 : S_DONE;
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        if (stat_i.f_zero) begin
          cmd_o.hold_zero = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_MUL2;
        end
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d = S_PGO;
      end
      S_PGO: begin
        cmd_o.p_start = 1'b1;
        state_d = S_PDIV;
      end
      S_PDIV: begin
        if (stat_i.div_done) begin
          cmd_o.p_latch = 1'b1;
          state_d = S_CAND;
        end
      end
      S_CAND: begin
        if (stat_i.psc_end) begin
          cmd_o.hold = 1'b1;  // no fit: step count and last reload
          state_d = S_DONE;
        end else if (stat_i.cand) begin
          cmd_o.q_start = 1'b1;
          state_d = S_QDIV;
        end else begin
          cmd_o.psc_inc = 1'b1;
        end
      end
      S_QDIV: begin
        if (stat_i.div_done) begin
          cmd_o.q_latch = 1'b1;
          state_d = S_FIT;
        end
      end
      S_FIT: begin
        cmd_o.fit = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (stat_i.fits) begin
          cmd_o.hold = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.psc_inc = 1'b1;
          state_d = S_CAND;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          ovalid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

  a_accept_to_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == S_CMP)
    else $error("accepted beat did not start compare");

  a_end_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CAND && stat_i.psc_end) |=> state_q == S_DONE)
    else $error("search ran past last prescaler");

  a_beat_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && state_q != S_DONE) |=> !out_valid_o)
    else $error("result beat repeated");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> slot_free)
    else $error("result overwritten before taken");

endmodule

// File: design/timer_prescale_reload_picker_core.sv
// Sequence: a change that is too small goes from compare to the result; a
//   recompute multiplies, divides for the period, then tries each prescaler,
//   dividing for the reload of each candidate on the shared bit-serial divider.
// Throughput: one item at a time; the next beat is taken once the last result
//   sits in the output register.
// Reset: async active low; registers to defaults, last freq 0, step 1 degree.
module timer_prescale_reload_picker_core #(
  parameter int unsigned PRESCALE_STEPS   = trp_pkg::PrescaleStepsDef,
  parameter int unsigned PERIOD_FRAC_BITS = trp_pkg::PeriodFracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [trp_pkg::FreqW-1:0]   freq_millihertz_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        updated_o,
  output logic [trp_pkg::PscW-1:0]    prescaler_o,
  output logic [trp_pkg::RelW-1:0]    reload_o,
  output logic [trp_pkg::StepW-1:0]   step_tenth_degree_o,
  output logic                        clamped_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [trp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [trp_pkg::FreqW-1:0]   cfg_data_i
);
  import trp_pkg::*;

  trp_cmd_t  cmd;
  trp_stat_t stat;

  // config writes are always taken
  assign cfg_ready_o = 1'b1;

  // sequencer: compare, period divide, then prescaler search
  trp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .out_valid_o, .out_ready_i,
    .stat_i(stat),
    .cmd_o (cmd)
  );

  // held state, config regs, divider and output beat register
  trp_dp #(
    .PRESCALE_STEPS  (PRESCALE_STEPS),
    .PERIOD_FRAC_BITS(PERIOD_FRAC_BITS)
  ) u_dp (
    .clk_i, .rst_ni,
    .cmd_i      (cmd),
    .stat_o     (stat),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .freq_i     (freq_millihertz_i),
    .updated_o,
    .prescaler_o,
    .reload_o,
    .step_o     (step_tenth_degree_o),
    .clamped_o
  );

endmodule
